### hdl/bblur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared widths, codes and types of the 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  // line store depth, widest frame supported
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 13;
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int CH_W      = 8;

  // nine 8-bit samples sum to 12 bits; 2*sum+count fits 13 bits
  localparam int SUM_W     = 12;
  localparam int NUM_W     = 13;
  localparam int CNT_W     = 4;
  localparam int DEN_W     = 5;
  localparam int QSTEPS    = 8;
  localparam int STEP_W    = $clog2(QSTEPS);
  localparam int DSH_W     = DEN_W + QSTEPS - 1;

  // APB register window
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam logic [WREG_W-1:0] WIDTH_RST  = WREG_W'(640);
  localparam logic [HREG_W-1:0] HEIGHT_RST = HREG_W'(480);

  // request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num_r;
    logic [NUM_W-1:0] num_g;
    logic [NUM_W-1:0] num_b;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] q_r;
    logic [CH_W-1:0] q_g;
    logic [CH_W-1:0] q_b;
  } div_rsp_t;

endpackage

### hdl/bblur_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pix_if
// Pixel input channel: valid/ready handshake with opcode and RGB payload.
// ----------------------------------------------------------------------------
interface bblur_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [bblur_pkg::CH_W-1:0] red_in;
  logic [bblur_pkg::CH_W-1:0] green_in;
  logic [bblur_pkg::CH_W-1:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

### hdl/bblur_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_res_if
// Blurred pixel output channel: valid/ready handshake with RGB and frame end.
// ----------------------------------------------------------------------------
interface bblur_res_if;
  logic                      valid;
  logic                      ready;
  logic [bblur_pkg::CH_W-1:0] red_out;
  logic [bblur_pkg::CH_W-1:0] green_out;
  logic [bblur_pkg::CH_W-1:0] blue_out;
  logic                      frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

### hdl/bblur_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module bblur_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bblur_pkg::div_req_t req_i,
  output bblur_pkg::div_rsp_t rsp_o
);
  import bblur_pkg::*;

  logic                        busy_q;
  logic                        done_q;
  logic [STEP_W-1:0]           step_q;
  logic [DSH_W-1:0]            dsh_q;
  logic [2:0][NUM_W-1:0]       rem_q, rem_d;
  logic [2:0][CH_W-1:0]        quo_q, quo_d;

  // quotient < 256 since num <= 511*count < 256*den, so 8 steps suffice
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (rem_q[ch] >= NUM_W'(dsh_q)) begin
        rem_d[ch] = rem_q[ch] - NUM_W'(dsh_q);
        quo_d[ch] = {quo_q[ch][CH_W-2:0], 1'b1};
      end else begin
        rem_d[ch] = rem_q[ch];
        quo_d[ch] = {quo_q[ch][CH_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QSTEPS - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q[0] <= req_i.num_r;
      rem_q[1] <= req_i.num_g;
      rem_q[2] <= req_i.num_b;
      dsh_q    <= {req_i.den, {(QSTEPS-1){1'b0}}};
      quo_q    <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q_r  = quo_q[0];
  assign rsp_o.q_g  = quo_q[1];
  assign rsp_o.q_b  = quo_q[2];

endmodule

### hdl/box_blur_3x3_edge_clipped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped
// 3x3 box blur over a raster RGB stream, neighbors clipped at the frame edge.
// ----------------------------------------------------------------------------
// After reset the block sweeps both line memories to zero and accepts no
// pixel meanwhile; APB writes are taken throughout. Pixels are handled one
// at a time: an item whose step yields a blurred pixel occupies the block
// through memory read, window update, sum, an eight-step quotient from the
// shared three-lane divider and output load; an item that yields none (first
// row of the frame, first pixel of the second) returns to idle after the
// window update; once the frame's last pixel has gone out further requests
// are taken each cycle and dropped until reset. Output lags input by width+1
// requests; send width+1 flush requests after the last pixel to drain. The
// output register lets the next request in while a result waits to be taken.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bblur_pkg::APB_AW-1:0]  paddr,
  input  logic [bblur_pkg::APB_DW-1:0]  pwdata,
  output logic [bblur_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  bblur_pix_if.sink                     pix_i,
  bblur_res_if.source                   res_o
);
  import bblur_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  clr_addr_q, clr_addr_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [1:0]        in_row_q, in_row_d;      // saturates at 2
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic              frame_done_q, frame_done_d;
  logic              out_valid_q;
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  rgb_t [2:0][2:0]   win_q, win_d;

  rgb_t              px_q;
  rgb_t              upper_rd_q, middle_rd_q;
  rgb_t              upper_mem  [MAX_WIDTH];
  rgb_t              middle_mem [MAX_WIDTH];
  logic              mem_we;
  logic [COL_W-1:0]  mem_waddr;
  rgb_t              upper_wdata, middle_wdata;

  logic [2:0]        row_ok_q, row_ok_d, col_ok_q, col_ok_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              fe_q, fe_d;
  rgb_t              res_q;
  logic              res_fe_q;
  logic              out_load;

  logic              pix_acc;
  logic              cfg_wr;
  logic              emit;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic [WREG_W-1:0] oc_ext;
  logic [ROW_W:0]    or_ext, h_ext;
  logic [1:0]        n_rows, n_cols;
  logic              in_wrap, out_wrap, row_last;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_IDX_HEIGHT) ? APB_DW'(height_q)
                                                         : APB_DW'(width_q);

  always_comb begin
    if (width_q == '0) begin
      w_eff = WREG_W'(1);
    end else if (width_q > WREG_W'(MAX_WIDTH)) begin
      w_eff = WREG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? HREG_W'(1) : height_q;
  end

  // --------------------------------------------------------------------------
  // position bookkeeping and edge masks
  // --------------------------------------------------------------------------
  assign pix_acc = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == ST_IDLE);

  assign emit   = (in_row_q == 2'd2) || ((in_row_q == 2'd1) && (in_col_q != '0));
  assign oc_ext = WREG_W'(out_col_q);
  assign or_ext = {1'b0, out_row_q};
  assign h_ext  = {1'b0, h_eff};

  always_comb begin
    col_ok_d[0] = (out_col_q != '0) && (oc_ext <= w_eff);
    col_ok_d[1] = oc_ext < w_eff;
    col_ok_d[2] = (oc_ext + 1'b1) < w_eff;
    row_ok_d[0] = (out_row_q != '0) && (out_row_q <= h_eff);
    row_ok_d[1] = out_row_q < h_eff;
    row_ok_d[2] = (or_ext + 1'b1) < h_ext;
    n_rows      = 2'($countones(row_ok_d));
    n_cols      = 2'($countones(col_ok_d));
    count_d     = CNT_W'(n_rows) * CNT_W'(n_cols);
  end

  assign in_wrap  = (WREG_W'(in_col_q) + 1'b1) >= w_eff;
  assign out_wrap = (oc_ext + 1'b1) >= w_eff;
  assign row_last = (or_ext + 1'b1) >= h_ext;

  // masked window sums over the nine taps
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        if (row_ok_q[k] && col_ok_q[l]) begin
          sum_r = sum_r + SUM_W'(win_q[k][l].r);
          sum_g = sum_g + SUM_W'(win_q[k][l].g);
          sum_b = sum_b + SUM_W'(win_q[k][l].b);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    frame_done_d = frame_done_q;
    win_d        = win_q;
    fe_d         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = in_col_q;
    upper_wdata  = middle_rd_q;
    middle_wdata = px_q;
    out_load     = 1'b0;
    div_req.start = 1'b0;
    div_req.den   = {count_q, 1'b0};
    div_req.num_r = {sum_r, 1'b0} + NUM_W'(count_q);
    div_req.num_g = {sum_g, 1'b0} + NUM_W'(count_q);
    div_req.num_b = {sum_b, 1'b0} + NUM_W'(count_q);

    case (state_q)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_q;
        upper_wdata  = '0;
        middle_wdata = '0;
        clr_addr_d   = clr_addr_q + 1'b1;
        if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // after frame end requests are taken and dropped
        if (pix_acc && !frame_done_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // read data of this column is in; shift window, rotate line stores
        mem_we = 1'b1;
        for (int k = 0; k < 3; k++) begin
          win_d[k][0] = win_q[k][1];
          win_d[k][1] = win_q[k][2];
        end
        win_d[0][2] = upper_rd_q;
        win_d[1][2] = middle_rd_q;
        win_d[2][2] = px_q;
        if (in_wrap) begin
          in_col_d = '0;
          if (in_row_q != 2'd2) begin
            in_row_d = in_row_q + 1'b1;
          end
        end else begin
          in_col_d = in_col_q + 1'b1;
        end
        if (emit) begin
          if (out_wrap) begin
            out_col_d = '0;
            if (row_last) begin
              frame_done_d = 1'b1;
              fe_d         = 1'b1;
            end else begin
              out_row_d = out_row_q + 1'b1;
            end
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
          state_d = ST_SUM;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      frame_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      win_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      frame_done_q <= frame_done_d;
      win_q        <= win_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[REG_SEL_BIT] == REG_IDX_HEIGHT) begin
          height_q <= pwdata[HREG_W-1:0];
        end else begin
          width_q <= pwdata[WREG_W-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers and line memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      px_q <= (pix_i.opcode == OP_FLUSH) ? '0
                                         : {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    end
    if (state_q == ST_UPD) begin
      row_ok_q <= row_ok_d;
      col_ok_q <= col_ok_d;
      count_q  <= count_d;
      fe_q     <= fe_d;
    end
    if (out_load) begin
      // no neighbor inside the frame gives zero
      if (count_q == '0) begin
        res_q <= '0;
      end else begin
        res_q <= {div_rsp.q_r, div_rsp.q_g, div_rsp.q_b};
      end
      res_fe_q <= fe_q;
    end
  end

  // one read per request, write-back in the following cycle: no overlap
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[mem_waddr]  <= upper_wdata;
      middle_mem[mem_waddr] <= middle_wdata;
    end
    if (pix_acc) begin
      upper_rd_q  <= upper_mem[in_col_q];
      middle_rd_q <= middle_mem[in_col_q];
    end
  end

  bblur_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_o.valid     = out_valid_q;
  assign res_o.red_out   = res_q.r;
  assign res_o.green_out = res_q.g;
  assign res_o.blue_out  = res_q.b;
  assign res_o.frame_end = res_fe_q;

endmodule

### hdl/bblur_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_chk
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bblur_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bblur_pkg::CH_W-1:0] red_out,
  input logic [bblur_pkg::CH_W-1:0] green_out,
  input logic [bblur_pkg::CH_W-1:0] blue_out,
  input logic                      frame_end
);
  import bblur_pkg::*;

  logic out_acc;
  assign out_acc = out_valid && out_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(frame_end))
    else $error("stalled result changed");

  // nothing follows the last pixel of a frame
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && frame_end |=> !out_valid)
    else $error("result after frame end");

  // a new result is only loaded while the block is busy on a request
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind box_blur_3x3_edge_clipped bblur_chk u_bblur_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_i.valid),
  .in_ready  (pix_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .red_out   (res_o.red_out),
  .green_out (res_o.green_out),
  .blue_out  (res_o.blue_out),
  .frame_end (res_o.frame_end)
);

### dv/box_blur_3x3_edge_clipped_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_test
// Self-checking bench for the edge-clipped 3x3 box blur. A local predictor
// keeps its own line rows, window and counters and computes any blurred pixel
// an accepted request yields. The monitor checks each output in order. The run
// holds a single frame: the geometry is changed between phases, and the last
// phase closes the frame and then sends requests that should be dropped.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_test;
  import bblur_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BUSY_CYCLES = 20;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 20;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic op;
    rgb_t px;
  } pix_req_t;

  typedef struct {
    rgb_t px;
    logic frame_end;
  } blurred_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  bblur_pix_if pix ();
  bblur_res_if res ();

  box_blur_3x3_edge_clipped DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix),
    .res_o   (res)
  );

  // predictor state
  logic [WREG_W-1:0] cfg_width  = WIDTH_RST;
  logic [HREG_W-1:0] cfg_height = HEIGHT_RST;
  rgb_t              upper_row [MAX_WIDTH];
  rgb_t              middle_row [MAX_WIDTH];
  rgb_t              win [9];
  int unsigned       col_in, row_in, col_out, row_out;
  bit                frame_closed;

  pix_req_t    pending [$];
  blurred_t    blurred_q [$];
  pix_req_t    offer;
  int          src_gap_pct;
  int          sink_stall_pct;
  int          hold_cycles;
  int          quiet_cycles;
  int          mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CH_W-1:0] rounded_mean(int unsigned sum, int unsigned cnt);
    if (cnt == 0) return '0;
    return CH_W'((2 * sum + cnt) / (2 * cnt));
  endfunction

  // one request through the blur; queues the blurred pixel it yields, if any
  function automatic void blur_predict(pix_req_t req);
    int unsigned w, h, idx, r, c, cnt, sum_r, sum_g, sum_b;
    rgb_t        px, v;
    blurred_t    px_out;
    if (frame_closed) return;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    px = (req.op == OP_FLUSH) ? '0 : req.px;
    idx = (col_in < MAX_WIDTH) ? col_in : 0;
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = upper_row[idx];
    win[5] = middle_row[idx];
    win[8] = px;
    upper_row[idx]  = middle_row[idx];
    middle_row[idx] = px;

    if (row_in >= 2 || (row_in == 1 && col_in >= 1)) begin
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt   = 0;
      // r and c are offset by one so the top/left neighbor sits at zero
      for (int k = 0; k < 3; k++) begin
        r = row_out + k;
        if (r < 1 || r - 1 >= h) continue;
        for (int l = 0; l < 3; l++) begin
          c = col_out + l;
          if (c < 1 || c - 1 >= w) continue;
          v = win[k * 3 + l];
          sum_r += v.r;
          sum_g += v.g;
          sum_b += v.b;
          cnt++;
        end
      end
      px_out.px.r      = rounded_mean(sum_r, cnt);
      px_out.px.g      = rounded_mean(sum_g, cnt);
      px_out.px.b      = rounded_mean(sum_b, cnt);
      px_out.frame_end = 1'b0;
      if (col_out + 1 >= w) begin
        col_out = 0;
        if (row_out + 1 >= h) begin
          frame_closed     = 1'b1;
          px_out.frame_end = 1'b1;
        end else begin
          row_out++;
        end
      end else begin
        col_out++;
      end
      blurred_q.push_back(px_out);
    end

    if (col_in + 1 >= w) begin
      col_in = 0;
      if (row_in < 'h3FFF) row_in++;
    end else begin
      col_in++;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) blur_predict(offer);
      if (!pix.valid || pix.ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          offer = pending.pop_front();
          pix.valid    <= 1'b1;
          pix.opcode   <= offer.op;
          pix.red_in   <= offer.px.r;
          pix.green_in <= offer.px.g;
          pix.blue_in  <= offer.px.b;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (blurred_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel %h %h %h frame_end %b", $time,
                   res.red_out, res.green_out, res.blue_out, res.frame_end);
        end else begin
          check_field("red_out", blurred_q[0].px.r, res.red_out);
          check_field("green_out", blurred_q[0].px.g, res.green_out);
          check_field("blue_out", blurred_q[0].px.b, res.blue_out);
          check_field("frame_end", blurred_q[0].frame_end, res.frame_end);
          void'(blurred_q.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("box_blur_3x3_edge_clipped: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic idx, int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_SEL_BIT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(int unsigned w_set, int unsigned h_set);
    reg_write(REG_IDX_WIDTH, w_set);
    reg_write(REG_IDX_HEIGHT, h_set);
    cfg_width  = WREG_W'(w_set);
    cfg_height = HREG_W'(h_set);
  endtask

  // wait until every request is taken and every blurred pixel has arrived;
  // requests with no output may still be in the block, so let it finish
  task automatic settle();
    while (pending.size() != 0 || pix.valid || blurred_q.size() != 0) @(negedge clk_i);
    repeat (BUSY_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SRC:  begin src_gap_pct = 45; sink_stall_pct = 0;  end
      IDLE_SINK: begin src_gap_pct = 0;  sink_stall_pct = 45; end
      default:   begin src_gap_pct = 28; sink_stall_pct = 28; end
    endcase
  endtask

  function automatic logic [CH_W-1:0] random_channel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(int unsigned n_items);
    pix_req_t req;
    repeat (n_items) begin
      req.op   = ($urandom_range(99) < 12) ? OP_FLUSH : OP_PIXEL;
      req.px.r = random_channel();
      req.px.g = random_channel();
      req.px.b = random_channel();
      pending.push_back(req);
    end
  endtask

  initial begin : stimulus
    logic [24:0] warmup [24];
    pix_req_t    req;
    int unsigned w_set, h_set, n_items, room;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix.valid    = 1'b0;
    pix.opcode   = OP_PIXEL;
    pix.red_in   = '0;
    pix.green_in = '0;
    pix.blue_in  = '0;
    res.ready    = 1'b0;
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;

    // width 3: full-range pixels, flushes inside the frame, bit patterns
    warmup = '{
      {OP_PIXEL, 24'hFFFFFF}, {OP_PIXEL, 24'h000000}, {OP_PIXEL, 24'hFFFFFF},
      {OP_FLUSH, 24'h5A5A5A}, {OP_PIXEL, 24'hFFFFFF}, {OP_PIXEL, 24'h000000},
      {OP_PIXEL, 24'hAA55FF}, {OP_PIXEL, 24'h55AA00}, {OP_FLUSH, 24'hFFFFFF},
      {OP_PIXEL, 24'hFFFFFF}, {OP_PIXEL, 24'hFFFFFF}, {OP_PIXEL, 24'hFFFFFF},
      {OP_PIXEL, 24'hFFFFFF}, {OP_PIXEL, 24'hFFFFFF}, {OP_PIXEL, 24'hFFFFFF},
      {OP_PIXEL, 24'h010203}, {OP_PIXEL, 24'h000001}, {OP_PIXEL, 24'h000000},
      {OP_PIXEL, 24'h808080}, {OP_PIXEL, 24'h7F7F7F}, {OP_FLUSH, 24'h000000},
      {OP_PIXEL, 24'hFF0000}, {OP_PIXEL, 24'h00FF00}, {OP_PIXEL, 24'h0000FF}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    configure(3, 8191);
    set_idle(IDLE_NONE);
    foreach (warmup[i]) begin
      req.op = warmup[i][24];
      req.px = warmup[i][23:0];
      pending.push_back(req);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      n_items = $urandom_range(30, 90);
      case (ph)
        0: w_set = 0;
        1: w_set = 2047;
        2: w_set = 1;
        3: w_set = 1024;
        default: begin
          case ($urandom_range(7))
            0:       w_set = 1;
            1:       w_set = 2;
            2:       w_set = 1024;
            default: w_set = $urandom_range(3, 24);
          endcase
        end
      endcase
      case ($urandom_range(2))
        0:       h_set = 8191;
        1:       h_set = 4096;
        default: h_set = $urandom_range(row_out + n_items + 3, 8191);
      endcase
      // short looks at a shrunken frame that stop before the output row wraps:
      // all neighbors outside, then the bottom edge
      if (ph == 6 || ph == 12) begin
        w_set   = 1024;
        room    = (col_out < 1023) ? 1023 - col_out : 0;
        n_items = (room < 12) ? room : 12;
        h_set   = (ph == 6) ? 0 : row_out + 1;
      end
      configure(w_set, h_set);
      set_idle(idle_mode_e'(ph % 4));
      // receiver holds off while requests keep coming, so the block backs up
      if (ph == 4) begin
        hold_cycles = LONG_HOLD;
        n_items     = 60;
      end
      queue_random(n_items);
    end

    // close the frame two output rows from here, then send requests to drop
    settle();
    w_set = $urandom_range(2, 6);
    configure(w_set, row_out + 2);
    set_idle(IDLE_BOTH);
    queue_random(3 * w_set + 8);

    while (pending.size() != 0 || pix.valid || blurred_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && blurred_q.size() == 0) begin
      $display("box_blur_3x3_edge_clipped: match");
    end else begin
      $display("box_blur_3x3_edge_clipped: mismatch");
    end
    $finish;
  end

endmodule
